[rtl/core/assert_macros.svh]
// Assertion macros for the checker file of the cell update core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock and active-low reset.
`define LSRK_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lsrk assertion failed");

// Same, on the house clock and reset names.
`define LSRK_ASSERT_CLK(label, prop) \
  `LSRK_ASSERT(label, clk_i, rst_ni, prop)

`endif

[rtl/core/lsrk_pkg.sv]
// Shared types, constants and coefficient helpers of the cell update core.
`timescale 1ns / 1ps

package lsrk_pkg;

  // Field widths
  localparam int VALUE_W    = 32;
  localparam int DT_W       = 32;
  localparam int DT_FRAC    = 24;
  localparam int STAGE_W    = 3;
  localparam int ORDER_W    = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int LIMB_W     = 32;
  localparam int RAT_W      = 64;

  // Cycles from an accepted word to its result strobe
  localparam int RESULT_LAT = 7;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCHEME_ORDER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP    = 1'b1;

  // Register reset values and order code
  localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd3;
  localparam logic [ORDER_W-1:0] ORDER_FOURTH = 3'd4;
  localparam logic [DT_W-1:0]    DT_RESET    = 32'h0100_0000;

  // Stage counts of the two schemes
  localparam logic [STAGE_W-1:0] STAGES_THREE = 3'd3;
  localparam logic [STAGE_W-1:0] STAGES_FIVE  = 3'd5;

  // Coefficient magnitudes as exact rationals (all nonzero cA are negative)
  localparam logic [RAT_W-1:0] A3_NUM [3] = '{64'd0, 64'd5, 64'd153};
  localparam logic [RAT_W-1:0] A3_DEN [3] = '{64'd1, 64'd9, 64'd128};
  localparam logic [RAT_W-1:0] B3_NUM [3] = '{64'd1, 64'd15, 64'd8};
  localparam logic [RAT_W-1:0] B3_DEN [3] = '{64'd3, 64'd16, 64'd15};
  localparam logic [RAT_W-1:0] A4_NUM [5] = '{64'd0, 64'd567301805773,
    64'd2404267990393, 64'd3550918686646, 64'd1275806237668};
  localparam logic [RAT_W-1:0] A4_DEN [5] = '{64'd1, 64'd1357537059087,
    64'd2016746695238, 64'd2091501179385, 64'd842570457699};
  localparam logic [RAT_W-1:0] B4_NUM [5] = '{64'd1432997174477, 64'd5161836677717,
    64'd1720146321549, 64'd3134564353537, 64'd2277821191437};
  localparam logic [RAT_W-1:0] B4_DEN [5] = '{64'd9575080441755, 64'd13612068292357,
    64'd2090206949498, 64'd4481467310338, 64'd14882151754819};

  typedef struct packed {
    logic [STAGE_W-1:0]        stage;
    logic                      in_interior;
    logic signed [VALUE_W-1:0] cell_value;
    logic signed [VALUE_W-1:0] cell_tendency;
  } lsrk_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] new_value;
    logic signed [VALUE_W-1:0] new_tendency;
    logic                      saturated;
    logic                      bad_stage;
  } lsrk_out_t;

  // num/den rounded to nearest (ties up) with frac fraction bits; ratio is below 2
  function automatic logic [RAT_W-1:0] coef_fixed(input logic [RAT_W-1:0] num,
                                                  input logic [RAT_W-1:0] den,
                                                  input int frac);
    logic [RAT_W-1:0] q;
    logic [RAT_W-1:0] rem;
    q   = (num >= den) ? 64'd1 : 64'd0;
    rem = (num >= den) ? num - den : num;
    for (int i = 0; i < frac; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= den) begin
        q   = q | 64'd1;
        rem = rem - den;
      end
    end
    rem = rem << 1;
    if (rem >= den) begin
      q = q + 64'd1;
    end
    return q;
  endfunction

endpackage

[rtl/core/lsrk_mul.sv]
// Two-stage limb multiplier: registered 32x32 partial products, then a registered sum.
`timescale 1ns / 1ps

module lsrk_mul #(
  parameter int A_W = 31,
  parameter int B_W = 32
) (
  input  logic               clk_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic [A_W+B_W-1:0] p_o
);
  import lsrk_pkg::*;

  localparam int NA    = (A_W + LIMB_W - 1) / LIMB_W;
  localparam int NB    = (B_W + LIMB_W - 1) / LIMB_W;
  localparam int PAD_A = NA * LIMB_W;
  localparam int PAD_B = NB * LIMB_W;
  localparam int SUM_W = PAD_A + PAD_B;

  logic [PAD_A-1:0]      a_pad;
  logic [PAD_B-1:0]      b_pad;
  logic [2*LIMB_W-1:0]   pp_q [NA][NB];
  logic [SUM_W-1:0]      sum_d;
  logic [A_W+B_W-1:0]    p_q;

  assign a_pad = PAD_A'(a_i);
  assign b_pad = PAD_B'(b_i);

  // stage 1: one 32x32 product per limb pair
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_q[i][j] <= a_pad[i*LIMB_W +: LIMB_W] * b_pad[j*LIMB_W +: LIMB_W];
      end
    end
  end

  // stage 2: weighted sum of the partial products
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum_d = sum_d + (SUM_W'(pp_q[i][j]) << (LIMB_W * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= sum_d[A_W+B_W-1:0];
  end

  assign p_o = p_q;

endmodule

[rtl/core/low_storage_rk_cell_update_core.sv]
// Top level: one low-storage Runge-Kutta stage update per grid cell, fully pipelined.
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+------------------------------------
//   command   | start_i / busy_o          | in_i  (stage, interior, value, tend)
//   result    | res_valid_o (strobe)      | res_o (value, tend, sat, bad_stage)
//   config    | cfg_we_i, cfg_idx_i       | cfg_data_i (scheme_order, time_step)
//
// A word enters in every cycle; after an input register it passes a chain of two limb
// multipliers (cB*dt, then *|tend|), each two stages, then a rounding stage and a
// saturation/output stage before its result strobes.
// busy_o stays low: the pipeline never stalls and the receiver cannot stall it.
// Reset sets scheme_order to 3 and time_step to 1.0 and empties the valid chain.
`timescale 1ns / 1ps

module low_storage_rk_cell_update_core #(
  parameter int COEF_FRAC_BITS = 30
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  lsrk_pkg::lsrk_in_t          in_i,
  input  logic                        cfg_we_i,
  input  logic [lsrk_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lsrk_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                        res_valid_o,
  output lsrk_pkg::lsrk_out_t         res_o
);
  import lsrk_pkg::*;

  localparam int VW    = VALUE_W;
  localparam int CW    = COEF_FRAC_BITS + 1;
  localparam int PB_W  = CW + DT_W;
  localparam int PV_W  = PB_W + VW;
  localparam int PT_W  = CW + VW;
  localparam int SH_V  = COEF_FRAC_BITS + DT_FRAC;
  localparam int SH_T  = COEF_FRAC_BITS;
  localparam int DEPTH = 6;

  localparam logic signed [VW+1:0] VMAX_X = {3'b000, {(VW-1){1'b1}}};
  localparam logic signed [VW+1:0] VMIN_X = {3'b111, {(VW-1){1'b0}}};
  localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  // Coefficient tables at the configured fraction width
  localparam logic [CW-1:0] CB3 [3] = '{
    CW'(coef_fixed(B3_NUM[0], B3_DEN[0], COEF_FRAC_BITS)),
    CW'(coef_fixed(B3_NUM[1], B3_DEN[1], COEF_FRAC_BITS)),
    CW'(coef_fixed(B3_NUM[2], B3_DEN[2], COEF_FRAC_BITS))};
  localparam logic [CW-1:0] CA3 [3] = '{
    CW'(coef_fixed(A3_NUM[0], A3_DEN[0], COEF_FRAC_BITS)),
    CW'(coef_fixed(A3_NUM[1], A3_DEN[1], COEF_FRAC_BITS)),
    CW'(coef_fixed(A3_NUM[2], A3_DEN[2], COEF_FRAC_BITS))};
  localparam logic [CW-1:0] CB4 [5] = '{
    CW'(coef_fixed(B4_NUM[0], B4_DEN[0], COEF_FRAC_BITS)),
    CW'(coef_fixed(B4_NUM[1], B4_DEN[1], COEF_FRAC_BITS)),
    CW'(coef_fixed(B4_NUM[2], B4_DEN[2], COEF_FRAC_BITS)),
    CW'(coef_fixed(B4_NUM[3], B4_DEN[3], COEF_FRAC_BITS)),
    CW'(coef_fixed(B4_NUM[4], B4_DEN[4], COEF_FRAC_BITS))};
  localparam logic [CW-1:0] CA4 [5] = '{
    CW'(coef_fixed(A4_NUM[0], A4_DEN[0], COEF_FRAC_BITS)),
    CW'(coef_fixed(A4_NUM[1], A4_DEN[1], COEF_FRAC_BITS)),
    CW'(coef_fixed(A4_NUM[2], A4_DEN[2], COEF_FRAC_BITS)),
    CW'(coef_fixed(A4_NUM[3], A4_DEN[3], COEF_FRAC_BITS)),
    CW'(coef_fixed(A4_NUM[4], A4_DEN[4], COEF_FRAC_BITS))};

  // Per-word side information that rides along the multipliers
  typedef struct packed {
    logic          interior;
    logic          bad;
    logic          wrap;
    logic          tneg;
    logic [VW-1:0] tmag;
    logic [VW-1:0] val;
    logic [VW-1:0] ten;
  } side_t;

  logic [ORDER_W-1:0] scheme_order_q;
  logic [DT_W-1:0]    time_step_q;

  logic               five;
  logic [STAGE_W-1:0] nst;
  side_t              side_d;
  side_t              side_q [DEPTH];
  logic               v_q [DEPTH];
  logic [CW-1:0]      cb_d, cb_q;
  logic [CW-1:0]      ca_d, ca_q;

  logic [PB_W-1:0]    prod_cb;
  logic [PV_W-1:0]    prod_v;
  logic [PT_W-1:0]    prod_t;
  logic [PT_W-1:0]    prod_t_q [2];

  logic [PV_W:0]      rnd_v;
  logic [PT_W:0]      rnd_t;
  logic [VW-1:0]      mag_v_q, mag_t_q;
  logic               big_v_q, big_t_q;

  logic signed [VW+1:0] sum_v;
  lsrk_out_t          res_d, res_q;
  logic               res_valid_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scheme_order_q <= ORDER_RESET;
      time_step_q    <= DT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCHEME_ORDER: scheme_order_q <= cfg_data_i[ORDER_W-1:0];
        CFG_TIME_STEP:    time_step_q    <= cfg_data_i[DT_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // Front end: stage decode, coefficient pick, tendency magnitude
  always_comb begin
    five = (scheme_order_q == ORDER_FOURTH);
    nst  = five ? STAGES_FIVE : STAGES_THREE;
    side_d.interior = in_i.in_interior;
    side_d.bad      = (in_i.stage >= nst);
    side_d.wrap     = ((in_i.stage + 3'd1) == nst);
    side_d.tneg     = in_i.cell_tendency[VW-1];
    side_d.tmag     = in_i.cell_tendency[VW-1] ? (~in_i.cell_tendency + 1'b1)
                                               : in_i.cell_tendency;
    side_d.val      = in_i.cell_value;
    side_d.ten      = in_i.cell_tendency;
    cb_d = '0;
    ca_d = '0;
    if (five) begin
      case (in_i.stage)
        3'd0: begin cb_d = CB4[0]; ca_d = CA4[1]; end
        3'd1: begin cb_d = CB4[1]; ca_d = CA4[2]; end
        3'd2: begin cb_d = CB4[2]; ca_d = CA4[3]; end
        3'd3: begin cb_d = CB4[3]; ca_d = CA4[4]; end
        3'd4: begin cb_d = CB4[4]; end
        default: ;
      endcase
    end else begin
      case (in_i.stage)
        3'd0: begin cb_d = CB3[0]; ca_d = CA3[1]; end
        3'd1: begin cb_d = CB3[1]; ca_d = CA3[2]; end
        3'd2: begin cb_d = CB3[2]; end
        default: ;
      endcase
    end
  end

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) begin
        v_q[k] <= 1'b0;
      end
      res_valid_q <= 1'b0;
    end else begin
      v_q[0] <= start_i;
      for (int k = 1; k < DEPTH; k++) begin
        v_q[k] <= v_q[k-1];
      end
      res_valid_q <= v_q[DEPTH-1];
    end
  end

  // Payload pipeline
  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    cb_q      <= cb_d;
    ca_q      <= ca_d;
    for (int k = 1; k < DEPTH; k++) begin
      side_q[k] <= side_q[k-1];
    end
    prod_t_q[0] <= prod_t;
    prod_t_q[1] <= prod_t_q[0];
  end

  // cB * dt
  lsrk_mul #(.A_W(CW), .B_W(DT_W)) u_mul_cb (
    .clk_i (clk_i),
    .a_i   (cb_q),
    .b_i   (time_step_q),
    .p_o   (prod_cb)
  );

  // cA * |tend|
  lsrk_mul #(.A_W(CW), .B_W(VW)) u_mul_ca (
    .clk_i (clk_i),
    .a_i   (ca_q),
    .b_i   (side_q[0].tmag),
    .p_o   (prod_t)
  );

  // (cB * dt) * |tend|
  lsrk_mul #(.A_W(PB_W), .B_W(VW)) u_mul_inc (
    .clk_i (clk_i),
    .a_i   (prod_cb),
    .b_i   (side_q[2].tmag),
    .p_o   (prod_v)
  );

  // Round half away from zero on magnitudes, flag anything past VW bits
  assign rnd_v = {1'b0, prod_v} + ((PV_W+1)'(1) << (SH_V - 1));
  assign rnd_t = {1'b0, prod_t_q[1]} + ((PT_W+1)'(1) << (SH_T - 1));

  always_ff @(posedge clk_i) begin
    mag_v_q <= rnd_v[SH_V +: VW];
    big_v_q <= |rnd_v[PV_W:SH_V+VW];
    mag_t_q <= rnd_t[SH_T +: VW];
    big_t_q <= |rnd_t[PT_W:SH_T+VW];
  end

  // Saturating update and result word
  always_comb begin
    logic sat_v;
    logic sat_t;
    sat_v = 1'b0;
    sat_t = 1'b0;
    sum_v = {{2{side_q[DEPTH-1].val[VW-1]}}, side_q[DEPTH-1].val}
          + (side_q[DEPTH-1].tneg ? -{2'b00, mag_v_q} : {2'b00, mag_v_q});
    res_d.new_value    = side_q[DEPTH-1].val;
    res_d.new_tendency = side_q[DEPTH-1].ten;
    res_d.bad_stage    = side_q[DEPTH-1].bad;
    if (!side_q[DEPTH-1].bad) begin
      if (side_q[DEPTH-1].interior) begin
        if (big_v_q) begin
          sat_v = 1'b1;
          res_d.new_value = side_q[DEPTH-1].tneg ? VMIN : VMAX;
        end else if (sum_v > VMAX_X) begin
          sat_v = 1'b1;
          res_d.new_value = VMAX;
        end else if (sum_v < VMIN_X) begin
          sat_v = 1'b1;
          res_d.new_value = VMIN;
        end else begin
          res_d.new_value = sum_v[VW-1:0];
        end
      end
      if (side_q[DEPTH-1].wrap) begin
        res_d.new_tendency = '0;
      end else if (side_q[DEPTH-1].interior) begin
        if (side_q[DEPTH-1].tneg) begin
          // tendency turns positive
          sat_t = big_t_q | mag_t_q[VW-1];
          res_d.new_tendency = sat_t ? VMAX : mag_t_q;
        end else begin
          // tendency turns negative; the most negative value still fits
          sat_t = big_t_q | (mag_t_q > VMIN);
          res_d.new_tendency = sat_t ? VMIN : VW'(~mag_t_q + 1'b1);
        end
      end
    end
    res_d.saturated = sat_v | sat_t;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[rtl/core/lsrk_checker.sv]
// Port-level checker of the cell update core, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lsrk_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_o,
  input lsrk_pkg::lsrk_in_t  in_i,
  input logic                res_valid_o,
  input lsrk_pkg::lsrk_out_t res_o
);
  import lsrk_pkg::*;

  // every accepted word gives exactly one result, a fixed latency later
  `LSRK_ASSERT_CLK(a_one_result, res_valid_o == $past(rst_ni && start_i && !busy_o, RESULT_LAT))

  // a stage no scheme has is always flagged, whatever the order
  `LSRK_ASSERT_CLK(a_bad_high_stage, (res_valid_o && ($past(in_i.stage, RESULT_LAT) >= STAGES_FIVE)) |-> res_o.bad_stage)

  // a bad stage passes the word through and never saturates
  `LSRK_ASSERT_CLK(a_bad_passes, (res_valid_o && res_o.bad_stage) |-> (!res_o.saturated && (res_o.new_value == $past(in_i.cell_value, RESULT_LAT)) && (res_o.new_tendency == $past(in_i.cell_tendency, RESULT_LAT))))

  // a halo cell keeps its value and never saturates
  `LSRK_ASSERT_CLK(a_halo_keeps, (res_valid_o && !$past(in_i.in_interior, RESULT_LAT)) |-> (!res_o.saturated && (res_o.new_value == $past(in_i.cell_value, RESULT_LAT))))

endmodule

bind low_storage_rk_cell_update_core lsrk_checker u_lsrk_checker (.*);
